[sv/fifo_queue_with_max_core_assert.svh]
// ----------------------------------------------------------------------------
// fifo_queue_with_max_core assertion macros
// Concurrent assertion wrappers shared by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_MAX_CORE_ASSERT_SVH
`define FIFO_QUEUE_WITH_MAX_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define FQM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FQM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FQM_ASSERT(lbl, prop, msg)

`define FQM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/fqm_pkg.sv]
// ----------------------------------------------------------------------------
// fqm_pkg
// Shared types and codes for the queue with maximum query.
// ----------------------------------------------------------------------------
package fqm_pkg;

    localparam int PORT_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic rotate;
        logic load;
    } cell_ctrl_t;

endpackage

[sv/fqm_cell.sv]
// ----------------------------------------------------------------------------
// fqm_cell
// One storage cell of the queue chain: holds, loads, or takes its neighbor.
// ----------------------------------------------------------------------------
module fqm_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  fqm_pkg::cell_ctrl_t           ctrl,
    input  logic signed [VALUE_WIDTH-1:0] neighbor,
    input  logic signed [VALUE_WIDTH-1:0] load_value,
    output logic signed [VALUE_WIDTH-1:0] value
);

    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = load_value;
        end
        else if (ctrl.rotate)
        begin
            value_next = neighbor;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[sv/fifo_queue_with_max_core.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_max_core
// FIFO of signed values that reports occupancy and the largest held value.
// ----------------------------------------------------------------------------
// Each item (push or pop) is handled in two steps: first the operation is
// applied to a chain of DEPTH cells whose first cell is the head, then the
// chain rotates once around its full length, one cell per cycle, while the
// head cell is compared against a running maximum. The chain ends up back in
// the order that the operation left. The next item is taken as soon as the
// rotation ends; a result not yet taken waits in the output register, and the
// following result stalls only until that one is taken. No initialization
// pass is needed after reset.
module fifo_queue_with_max_core #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              kind,
    input  logic signed [fqm_pkg::PORT_W-1:0] push_value,

    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [fqm_pkg::STATUS_W-1:0]      status,
    output logic signed [fqm_pkg::PORT_W-1:0] popped_value,
    output logic [$clog2(DEPTH + 1)-1:0]      occupancy,
    output logic                              is_empty,
    output logic signed [fqm_pkg::PORT_W-1:0] largest_value
);

`include "fifo_queue_with_max_core_assert.svh"

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              result_valid_reg, result_valid_next;

    logic [fqm_pkg::STATUS_W-1:0]  status_pend_reg, status_pend_next;
    logic signed [VALUE_WIDTH-1:0] popped_pend_reg, popped_pend_next;
    logic signed [VALUE_WIDTH-1:0] acc_reg, acc_next;

    logic [fqm_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic signed [VALUE_WIDTH-1:0] popped_reg, popped_next;
    logic [CNT_W-1:0]              occ_reg, occ_next;
    logic signed [VALUE_WIDTH-1:0] largest_reg, largest_next;

    logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
    fqm_pkg::cell_ctrl_t           cell_ctrl  [DEPTH];
    logic signed [VALUE_WIDTH-1:0] push_ext;
    logic signed [VALUE_WIDTH-1:0] head_value;

    logic item_xfer, result_xfer;
    logic push_ok, pop_ok;
    logic is_full, is_none;
    logic walk_last, out_free;
    logic in_range, take_head;
    logic signed [VALUE_WIDTH-1:0] walk_max;

    assign push_ext   = VALUE_WIDTH'(push_value);
    assign head_value = cell_value[0];

    assign item_ready  = (state_reg == S_IDLE);
    assign item_xfer   = item_valid && item_ready;
    assign result_xfer = result_valid_reg && result_ready;
    assign out_free    = !result_valid_reg || result_ready;

    assign is_full = (count_reg == CNT_W'(DEPTH));
    assign is_none = (count_reg == '0);
    assign push_ok = item_xfer && (kind == fqm_pkg::KIND_PUSH) && !is_full;
    assign pop_ok  = item_xfer && (kind == fqm_pkg::KIND_POP) && !is_none;

    assign walk_last = (step_reg == STEP_W'(DEPTH - 1));
    assign in_range  = (CNT_W'(step_reg) < count_reg);
    assign take_head = in_range && ((step_reg == '0) || (head_value > acc_reg));
    assign walk_max  = take_head ? head_value : acc_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_ctrl[gi].rotate = pop_ok || (state_reg == S_WALK);
            assign cell_ctrl[gi].load   = push_ok && (count_reg == CNT_W'(gi));

            fqm_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .neighbor   (cell_value[(gi + 1) % DEPTH]),
                .load_value (push_ext),
                .value      (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg;
        status_pend_next  = status_pend_reg;
        popped_pend_next  = popped_pend_reg;
        acc_next          = acc_reg;
        status_next       = status_reg;
        popped_next       = popped_reg;
        occ_next          = occ_reg;
        largest_next      = largest_reg;

        if (result_xfer)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    status_pend_next = fqm_pkg::ST_OK;
                    popped_pend_next = '0;
                    if (kind == fqm_pkg::KIND_PUSH)
                    begin
                        if (is_full)
                        begin
                            status_pend_next = fqm_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (is_none)
                        begin
                            status_pend_next = fqm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            popped_pend_next = head_value;
                            count_next       = count_reg - 1'b1;
                        end
                    end
                    step_next  = '0;
                    acc_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                acc_next  = walk_max;
                step_next = step_reg + 1'b1;
                if (walk_last)
                begin
                    step_next = '0;
                    if (out_free)
                    begin
                        status_next       = status_pend_reg;
                        popped_next       = popped_pend_reg;
                        occ_next          = count_reg;
                        largest_next      = walk_max;
                        result_valid_next = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    status_next       = status_pend_reg;
                    popped_next       = popped_pend_reg;
                    occ_next          = count_reg;
                    largest_next      = acc_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_pend_reg <= status_pend_next;
        popped_pend_reg <= popped_pend_next;
        acc_reg         <= acc_next;
        status_reg      <= status_next;
        popped_reg      <= popped_next;
        occ_reg         <= occ_next;
        largest_reg     <= largest_next;
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign popped_value  = fqm_pkg::PORT_W'($unsigned(popped_reg));
    assign occupancy     = occ_reg;
    assign is_empty      = (occ_reg == '0);
    assign largest_value = fqm_pkg::PORT_W'($unsigned(largest_reg));

    `FQM_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `FQM_ASSERT_NEXT(a_push_count, push_ok, count_reg == $past(count_reg) + 1'b1, "push count")
    `FQM_ASSERT_NEXT(a_pop_count, pop_ok, count_reg == $past(count_reg) - 1'b1, "pop count")
    `FQM_ASSERT_NEXT(a_walk_done, (state_reg == S_WALK) && walk_last && out_free, result_valid_reg && (state_reg == S_IDLE), "walk end without result")
    `FQM_ASSERT(a_empty_max, (result_valid_reg && (occ_reg == '0)) |-> (largest_reg == '0), "nonzero max on empty")

endmodule
